// File: design/amix_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the audio mixer.
// No dependencies; imported by amix_ctrl and the top level.
package amix_pkg;

   localparam int RING_FRAMES  = 8192;
   localparam int STREAM_COUNT = 16;

   localparam int PTR_W    = $clog2(RING_FRAMES);
   localparam int SCAN_W   = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
   localparam int STREAM_W = 4;
   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 20;
   localparam int MIX_W    = 2 * ACC_W;
   localparam int FILL_W   = 13;
   localparam int LIMIT_W  = 13;
   localparam int IDLE_W   = 3;
   localparam int STATUS_W = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT  = 1'b1;

   localparam logic [LIMIT_W-1:0] DELAY_LIMIT_RESET = 13'd2048;
   localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RESET  = 3'd4;
   localparam logic [IDLE_W-1:0]  IDLE_MAX          = 3'd7;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RETRY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERRUN = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_PTR,
      ST_WR_ACC,
      ST_SCAN,
      ST_DECIDE,
      ST_RD_MIX,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] delay_limit;
      logic [IDLE_W-1:0]  idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SAMPLE_W-1:0] left_out;
      logic [SAMPLE_W-1:0] right_out;
      logic [FILL_W-1:0]   fill_level;
      logic                pause_writer;
   } result_type;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic [MIX_W-1:0] wdata;
      logic [PTR_W-1:0] raddr;
   } mix_req_type;

   typedef struct packed {
      logic              we;
      logic [SCAN_W-1:0] waddr;
      logic [PTR_W-1:0]  wdata;
      logic [SCAN_W-1:0] raddr;
   } ptr_req_type;

   function automatic logic [SAMPLE_W-1:0] sat16(input logic [ACC_W-1:0] acc);
      logic fits;
      fits = (&acc[ACC_W-1:SAMPLE_W-1]) | ~(|acc[ACC_W-1:SAMPLE_W-1]);
      if (fits) begin
         sat16 = acc[SAMPLE_W-1:0];
      end else if (acc[ACC_W-1]) begin
         sat16 = SAMPLE_MIN;
      end else begin
         sat16 = SAMPLE_MAX;
      end
   endfunction

   function automatic logic [ACC_W-1:0] sext(input logic [SAMPLE_W-1:0] s);
      sext = {{(ACC_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
   endfunction

   function automatic logic pause_of(input logic [PTR_W-1:0] fill,
                                     input logic [LIMIT_W-1:0] limit);
      pause_of = (32'(fill) >= 32'(limit));
   endfunction

endpackage

// File: design/amix_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module amix_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/amix_ctrl.sv
`timescale 1ns / 1ps
// Mixer sequencer: request decode, pointer scan, accumulate and read-out.
// Depends on amix_pkg; drives the mix and pointer RAMs held by the top level.
module amix_ctrl
   import amix_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [STREAM_W-1:0] req_stream_index,
   input  logic [SAMPLE_W-1:0] req_left_sample,
   input  logic [SAMPLE_W-1:0] req_right_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output result_type          rsp,
   output mix_req_type         mix_req,
   input  logic [MIX_W-1:0]    mix_rdata,
   output ptr_req_type         ptr_req,
   input  logic [PTR_W-1:0]    ptr_rdata
);

   state_type state_ff, state_in;

   logic [STREAM_W-1:0]     stream_ff, stream_in;
   logic [SAMPLE_W-1:0]     left_ff, left_in;
   logic [SAMPLE_W-1:0]     right_ff, right_in;
   logic [PTR_W-1:0]        rp_ff, rp_in;
   logic [STREAM_COUNT-1:0] running_ff, running_in;
   logic [IDLE_W-1:0]       idle_cnt_ff, idle_cnt_in;
   logic [SCAN_W-1:0]       scan_ff, scan_in;
   logic                    any_ff, any_in;
   logic                    empty_ff, empty_in;
   logic [PTR_W-1:0]        slot_ff, slot_in;
   logic [PTR_W-1:0]        fill_ff, fill_in;
   logic [PTR_W-1:0]        clr_ff, clr_in;
   result_type              res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   logic              stream_ok;
   logic [SCAN_W-1:0] stream_sel;
   logic [PTR_W-1:0]  wp_eff;
   logic [PTR_W-1:0]  wr_fill;
   logic              wr_full;
   logic [PTR_W-1:0]  wr_fill_next;
   logic [PTR_W-1:0]  scan_fill;
   logic              scan_last;
   logic              underrun;
   logic              load_ok;
   logic [ACC_W-1:0]  acc_left;
   logic [ACC_W-1:0]  acc_right;

   assign stream_ok    = (32'(req_stream_index) < STREAM_COUNT);
   assign stream_sel   = SCAN_W'(stream_ff);
   assign wp_eff       = running_ff[stream_sel] ? ptr_rdata : rp_ff;
   assign wr_fill      = wp_eff - rp_ff;
   assign wr_full      = (wr_fill == PTR_W'(RING_FRAMES - 1));
   assign wr_fill_next = fill_ff + PTR_W'(1);
   assign scan_fill    = ptr_rdata - rp_ff;
   assign scan_last    = (scan_ff == SCAN_W'(STREAM_COUNT - 1));
   assign underrun     = !any_ff || empty_ff;
   assign load_ok      = !rsp_valid_ff || rsp_ready;
   assign acc_left     = mix_rdata[ACC_W-1:0] + sext(left_ff);
   assign acc_right    = mix_rdata[MIX_W-1:ACC_W] + sext(right_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == PTR_W'(RING_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_cmd == CMD_READ) begin
                  state_in = ST_SCAN;
               end else if (stream_ok) begin
                  state_in = ST_WR_PTR;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WR_PTR: state_in = wr_full ? ST_RESP : ST_WR_ACC;
         ST_WR_ACC: state_in = ST_RESP;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = underrun ? ST_RESP : ST_RD_MIX;
         ST_RD_MIX: state_in = ST_RESP;
         ST_RESP: begin
            if (load_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      stream_in   = stream_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      rp_in       = rp_ff;
      running_in  = running_ff;
      idle_cnt_in = idle_cnt_ff;
      scan_in     = scan_ff;
      any_in      = any_ff;
      empty_in    = empty_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      clr_in      = clr_ff;
      res_in      = res_ff;
      mix_req     = '0;
      ptr_req     = '0;
      mix_req.raddr = rp_ff;
      ptr_req.raddr = scan_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mix_req.we    = 1'b1;
            mix_req.waddr = clr_ff;
            clr_in        = clr_ff + PTR_W'(1);
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            ptr_req.raddr = (req_cmd == CMD_READ) ? '0 : SCAN_W'(req_stream_index);
            if (req_valid) begin
               stream_in = req_stream_index;
               left_in   = req_left_sample;
               right_in  = req_right_sample;
               scan_in   = '0;
               any_in    = 1'b0;
               empty_in  = 1'b0;
               res_in    = '0;
            end
         end
         ST_WR_PTR: begin
            running_in[stream_sel] = 1'b1;
            slot_in       = wp_eff;
            fill_in       = wr_fill;
            mix_req.raddr = wp_eff;
            if (wr_full) begin
               res_in              = '0;
               res_in.status       = STATUS_RETRY;
               res_in.fill_level   = FILL_W'(wr_fill);
               res_in.pause_writer = pause_of(wr_fill, cfg.delay_limit);
            end else begin
               ptr_req.we    = 1'b1;
               ptr_req.waddr = stream_sel;
               ptr_req.wdata = wp_eff + PTR_W'(1);
            end
         end
         ST_WR_ACC: begin
            mix_req.we          = 1'b1;
            mix_req.waddr       = slot_ff;
            mix_req.wdata       = {acc_right, acc_left};
            res_in              = '0;
            res_in.status       = STATUS_DONE;
            res_in.fill_level   = FILL_W'(wr_fill_next);
            res_in.pause_writer = pause_of(wr_fill_next, cfg.delay_limit);
         end
         ST_SCAN: begin
            ptr_req.raddr = scan_ff + SCAN_W'(1);
            scan_in       = scan_ff + SCAN_W'(1);
            if (running_ff[scan_ff]) begin
               if (scan_fill == '0 && idle_cnt_ff > cfg.idle_limit) begin
                  running_in[scan_ff] = 1'b0;
               end else begin
                  any_in = 1'b1;
                  if (scan_fill == '0) begin
                     empty_in = 1'b1;
                  end
               end
            end
         end
         ST_DECIDE: begin
            mix_req.raddr = rp_ff;
            if (underrun) begin
               if (idle_cnt_ff < IDLE_MAX) begin
                  idle_cnt_in = idle_cnt_ff + IDLE_W'(1);
               end
               res_in        = '0;
               res_in.status = STATUS_UNDERRUN;
            end
         end
         ST_RD_MIX: begin
            mix_req.we       = 1'b1;
            mix_req.waddr    = rp_ff;
            mix_req.wdata    = '0;
            rp_in            = rp_ff + PTR_W'(1);
            idle_cnt_in      = '0;
            res_in           = '0;
            res_in.status    = STATUS_DONE;
            res_in.left_out  = sat16(mix_rdata[ACC_W-1:0]);
            res_in.right_out = sat16(mix_rdata[MIX_W-1:ACC_W]);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (state_ff == ST_RESP && load_ok) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rp_ff        <= '0;
         running_ff   <= '0;
         idle_cnt_ff  <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         running_ff   <= running_in;
         idle_cnt_ff  <= idle_cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stream_ff <= stream_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      scan_ff   <= scan_in;
      any_ff    <= any_in;
      empty_ff  <= empty_in;
      slot_ff   <= slot_in;
      fill_ff   <= fill_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: design/multi_stream_audio_mixer_top.sv
`timescale 1ns / 1ps
// Top level of the multi-stream audio mixer: CSRs, mix RAM, pointer RAM.
// Depends on amix_pkg, amix_ram and amix_ctrl.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   request  | req_valid/req_ready  | cmd, stream_index, left_sample, right_sample
//   response | rsp_valid/rsp_ready  | status, left_out, right_out, fill_level, pause
//   csr      | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A write request runs the pointer and accumulate states (the latter skipped on a
// full ring), a read request the scan, decide and, with a frame, read-out states;
// the read time is set by the serial scan of the 16-entry stream-pointer RAM, one
// entry per cycle. After reset a clearing pass writes zero to all 8192 mix RAM
// slots; req_ready stays low until it ends, while CSR writes are always taken.
// The response register holds a result while rsp_ready is low; the next request is
// still accepted and its result waits in the sequencer until the register frees.
module multi_stream_audio_mixer_top
   import amix_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [STREAM_W-1:0]        req_stream_index,
   input  logic signed [SAMPLE_W-1:0] req_left_sample,
   input  logic signed [SAMPLE_W-1:0] req_right_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic [FILL_W-1:0]          rsp_fill_level,
   output logic                       rsp_pause_writer,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   result_type  rsp;
   mix_req_type mix_req;
   ptr_req_type ptr_req;
   logic [MIX_W-1:0] mix_rdata;
   logic [PTR_W-1:0] ptr_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DELAY_LIMIT: cfg_in.delay_limit = LIMIT_W'(csr_wdata);
            CSR_IDLE_LIMIT:  cfg_in.idle_limit  = csr_wdata[IDLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_limit <= DELAY_LIMIT_RESET;
         cfg_ff.idle_limit  <= IDLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amix_ram #(
      .WIDTH (MIX_W),
      .DEPTH (RING_FRAMES)
   ) u_mix_ram (
      .clock (clock),
      .we    (mix_req.we),
      .waddr (mix_req.waddr),
      .wdata (mix_req.wdata),
      .raddr (mix_req.raddr),
      .rdata (mix_rdata)
   );

   amix_ram #(
      .WIDTH (PTR_W),
      .DEPTH (STREAM_COUNT)
   ) u_ptr_ram (
      .clock (clock),
      .we    (ptr_req.we),
      .waddr (ptr_req.waddr),
      .wdata (ptr_req.wdata),
      .raddr (ptr_req.raddr),
      .rdata (ptr_rdata)
   );

   amix_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_stream_index (req_stream_index),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp),
      .mix_req          (mix_req),
      .mix_rdata        (mix_rdata),
      .ptr_req          (ptr_req),
      .ptr_rdata        (ptr_rdata)
   );

   assign rsp_status       = rsp.status;
   assign rsp_left_out     = rsp.left_out;
   assign rsp_right_out    = rsp.right_out;
   assign rsp_fill_level   = rsp.fill_level;
   assign rsp_pause_writer = rsp.pause_writer;

endmodule
